[hdl/mbf_pkg.sv]
// Shared types and constants for the metaball field pixel shader.
// Depends on nothing; every other file refers to it by scoped names.
package mbf_pkg;

  localparam int NumBallsDef    = 6;
  localparam int PosFracBitsDef = 4;
  localparam int VelFrac        = 4;

  localparam logic [23:0] Sat24 = 24'hFFFFFF;

  localparam logic [15:0] ThresholdRst = 16'd50;
  localparam logic [10:0] WidthRst     = 11'd640;
  localparam logic [10:0] HeightRst    = 11'd480;
  localparam logic [31:0] FgRst        = 32'hFFFFFF00;
  localparam logic [31:0] BgRst        = 32'h51515100;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_WIDTH     = 3'd1,
    CFG_HEIGHT    = 3'd2,
    CFG_FG        = 3'd3,
    CFG_BG        = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_SQRT,
    ST_DIV,
    ST_ACC,
    ST_OUT,
    ST_FRAME
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // write ball from input item
    logic pix_start; // latch pixel, clear sum
    logic sq_dist;   // compute squared distance of current ball
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic acc;       // add term
    logic frame;     // move current ball
    logic next_ball;
    logic first_ball;
    logic out_load;
  } mbf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_ball;
    logic skip;      // current ball radius zero
    logic sqrt_done;
    logic div_done;
  } mbf_sts_t;

endpackage

[hdl/metaball_field_pixel_shader_top.sv]
// Channel   | Ports                                   | Moves
// in        | in_valid, in_stall, in_* fields          | one action transaction
// out       | out_valid, out_stall, out_* fields       | one pixel result transaction
// cfg       | cfg_we, cfg_index, cfg_data              | register write
// A pixel runs, for each ball of nonzero radius, the distance, square root, divide
// and accumulate steps in that order, and skips each ball of zero radius; the
// bit-serial square root and divider are shared across the balls in turn.
// A load writes the ball table while idle; a frame moves each ball in turn.
// Reset (rst_n low, synchronous) clears config registers to defaults, balls to zero.
// The result register holds while valid and stalled; a finished pixel waits for it.
// Depends on mbf_pkg, mbf_ctrl and mbf_datapath.
module metaball_field_pixel_shader_top #(
  parameter int NUM_BALLS     = mbf_pkg::NumBallsDef,
  parameter int POS_FRAC_BITS = mbf_pkg::PosFracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_ball_index,
  input  logic [10:0]        in_pixel_x,
  input  logic [10:0]        in_pixel_y,
  input  logic signed [15:0] in_load_pos_x,
  input  logic signed [15:0] in_load_pos_y,
  input  logic signed [7:0]  in_load_vel_x,
  input  logic signed [7:0]  in_load_vel_y,
  input  logic [5:0]         in_load_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_pixel_color,
  output logic               out_lit,
  output logic [23:0]        out_field_sum,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [15:0] threshold_r;
  logic [10:0] width_r, height_r;
  logic [31:0] fg_r, bg_r;
  logic        out_valid_r;
  logic [31:0] color_r;
  logic        lit_r;
  logic [23:0] fsum_r;

  mbf_pkg::mbf_cmd_t cmd;
  mbf_pkg::mbf_sts_t sts;
  logic [23:0]       sum;
  logic              lit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= mbf_pkg::ThresholdRst;
      width_r     <= mbf_pkg::WidthRst;
      height_r    <= mbf_pkg::HeightRst;
      fg_r        <= mbf_pkg::FgRst;
      bg_r        <= mbf_pkg::BgRst;
    end else if (cfg_we) begin
      case (mbf_pkg::cfg_index_t'(cfg_index))
        mbf_pkg::CFG_THRESHOLD: threshold_r <= cfg_data[15:0];
        mbf_pkg::CFG_WIDTH:     width_r     <= cfg_data[10:0];
        mbf_pkg::CFG_HEIGHT:    height_r    <= cfg_data[10:0];
        mbf_pkg::CFG_FG:        fg_r        <= cfg_data;
        mbf_pkg::CFG_BG:        bg_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  mbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_busy  (out_valid_r && out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbf_datapath #(
    .NUM_BALLS     (NUM_BALLS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_ball_index  (in_ball_index),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_load_pos_x  (in_load_pos_x),
    .in_load_pos_y  (in_load_pos_y),
    .in_load_vel_x  (in_load_vel_x),
    .in_load_vel_y  (in_load_vel_y),
    .in_load_radius (in_load_radius),
    .bound_x        (width_r),
    .bound_y        (height_r),
    .sum            (sum)
  );

  assign lit = (sum >= {threshold_r, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        color_r     <= lit ? fg_r : bg_r;
        lit_r       <= lit;
        fsum_r      <= sum;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;
  assign out_lit         = lit_r;
  assign out_field_sum   = fsum_r;

endmodule

[hdl/mbf_ctrl.sv]
// Controller state machine for the metaball field pixel shader.
// Depends on mbf_pkg.
module mbf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic                out_busy,
  input  mbf_pkg::mbf_sts_t   sts,
  output mbf_pkg::mbf_cmd_t   cmd
);

  mbf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      mbf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.first_ball = 1'b1;
          case (mbf_pkg::action_t'(in_action))
            mbf_pkg::ACT_LOAD:  cmd.load = 1'b1;
            mbf_pkg::ACT_PIXEL: begin
              cmd.pix_start = 1'b1;
              state_nxt     = mbf_pkg::ST_DIST;
            end
            mbf_pkg::ACT_FRAME: state_nxt = mbf_pkg::ST_FRAME;
            default: ;
          endcase
        end
      end
      mbf_pkg::ST_DIST: begin
        if (sts.skip) begin
          if (sts.last_ball) begin
            state_nxt = mbf_pkg::ST_OUT;
          end else begin
            cmd.next_ball = 1'b1;
          end
        end else begin
          cmd.sq_dist = 1'b1;
          state_nxt   = mbf_pkg::ST_SQRT;
        end
      end
      mbf_pkg::ST_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = mbf_pkg::ST_DIV;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      mbf_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = mbf_pkg::ST_ACC;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      mbf_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last_ball) begin
          state_nxt = mbf_pkg::ST_OUT;
        end else begin
          cmd.next_ball = 1'b1;
          state_nxt     = mbf_pkg::ST_DIST;
        end
      end
      mbf_pkg::ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = mbf_pkg::ST_IDLE;
        end
      end
      mbf_pkg::ST_FRAME: begin
        cmd.frame = 1'b1;
        if (sts.last_ball) begin
          state_nxt = mbf_pkg::ST_IDLE;
        end else begin
          cmd.next_ball = 1'b1;
        end
      end
      default: state_nxt = mbf_pkg::ST_IDLE;
    endcase
  end

endmodule

[hdl/mbf_datapath.sv]
// Ball table, distance, iterative square root and divider, and frame motion.
// Depends on mbf_pkg.
module mbf_datapath #(
  parameter int NUM_BALLS     = mbf_pkg::NumBallsDef,
  parameter int POS_FRAC_BITS = mbf_pkg::PosFracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mbf_pkg::mbf_cmd_t  cmd,
  output mbf_pkg::mbf_sts_t  sts,
  input  logic [2:0]         in_ball_index,
  input  logic [10:0]        in_pixel_x,
  input  logic [10:0]        in_pixel_y,
  input  logic signed [15:0] in_load_pos_x,
  input  logic signed [15:0] in_load_pos_y,
  input  logic signed [7:0]  in_load_vel_x,
  input  logic signed [7:0]  in_load_vel_y,
  input  logic [5:0]         in_load_radius,
  input  logic [10:0]        bound_x,
  input  logic [10:0]        bound_y,
  output logic [23:0]        sum
);

  localparam int IdxW = (NUM_BALLS > 1) ? $clog2(NUM_BALLS) : 1;
  localparam int F    = POS_FRAC_BITS;
  // Pixel coordinate scaled by 2^F, plus sign.
  localparam int PW   = 11 + F + 1;
  localparam int DW   = (PW > 17 ? PW : 17) + 1;
  localparam int D2W  = 2 * DW;
  localparam int RW   = D2W / 2 + 1;
  localparam int SqIt = (D2W + 1) / 2;
  // Numerator 100*r*256*2^F, r < 64.
  localparam int NW   = 13 + 8 + F + 1;
  localparam int QW   = NW;
  localparam int CntW = $clog2((SqIt > QW ? SqIt : QW) + 1);

  logic signed [15:0] pos_x_r [NUM_BALLS];
  logic signed [15:0] pos_y_r [NUM_BALLS];
  logic signed [7:0]  vel_x_r [NUM_BALLS];
  logic signed [7:0]  vel_y_r [NUM_BALLS];
  logic [5:0]         rad_r   [NUM_BALLS];

  logic [IdxW-1:0] idx_r;
  logic [10:0]     px_r, py_r;
  logic [23:0]     sum_r;

  logic [D2W-1:0]  rem_r;
  logic [RW-1:0]   root_r;
  logic [D2W-1:0]  sq_src_r;
  logic [CntW-1:0] cnt_r;
  logic [QW-1:0]   quo_r;
  logic [RW:0]     drem_r;
  logic [NW-1:0]   num_r;

  logic signed [DW-1:0] dx, dy;
  logic [D2W-1:0]       dxx, dyy;

  assign dx  = $signed(DW'({1'b0, px_r}) << F) - DW'(pos_x_r[idx_r]);
  assign dy  = $signed(DW'({1'b0, py_r}) << F) - DW'(pos_y_r[idx_r]);

  // Pipeline: squares registered in DIST, combined at sqrt init.
  logic [D2W-1:0] sqx_r, sqy_r;
  logic           sq_load_r;
  assign dxx = $unsigned(D2W'(dx) * D2W'(dx));
  assign dyy = $unsigned(D2W'(dy) * D2W'(dy));

  assign sts.last_ball = (32'(idx_r) == NUM_BALLS - 1);
  assign sts.skip      = (rad_r[idx_r] == 6'd0);
  assign sts.sqrt_done = !sq_load_r && (cnt_r == CntW'(SqIt));
  assign sts.div_done  = (cnt_r == CntW'(QW));
  assign sum           = sum_r;

  // Restoring square root, two bits of the radicand per step.
  logic [RW+1:0]  trial;
  logic [D2W-1:0] rem_sh;
  assign rem_sh = {rem_r[D2W-3:0], sq_src_r[D2W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  // Restoring divide of the numerator by the root.
  logic [RW:0] dsh;
  assign dsh = {drem_r[RW-1:0], num_r[NW-1]};

  logic [NW-1:0] numer;
  assign numer = (NW'(rad_r[idx_r]) * NW'(100)) << (8 + F);

  logic [24:0] acc_sum;
  logic [23:0] term;
  assign term    = (root_r == '0) ? mbf_pkg::Sat24 :
                   ((quo_r > QW'(mbf_pkg::Sat24)) ? mbf_pkg::Sat24 : quo_r[23:0]);
  assign acc_sum = {1'b0, sum_r} + {1'b0, term};

  // Frame motion of the current ball.
  function automatic logic signed [7:0] neg8(input logic signed [7:0] v);
    neg8 = (v == -8'sd128) ? 8'sd127 : -v;
  endfunction

  function automatic logic signed [15:0] move(input logic signed [15:0] p,
                                              input logic signed [7:0] v);
    logic signed [17:0] av;
    logic signed [17:0] s;
    if (F >= mbf_pkg::VelFrac) av = 18'(v) <<< (F - mbf_pkg::VelFrac);
    else                      av = 18'(v) >>> (mbf_pkg::VelFrac - F);
    s = 18'(p) + av;
    if (s > 18'sd32767)       move = 16'sh7FFF;
    else if (s < -18'sd32768) move = 16'sh8000;
    else                      move = s[15:0];
  endfunction

  logic signed [7:0] nvx, nvy;
  logic signed [19:0] hix, hiy;
  assign hix = $signed(20'({1'b0, bound_x}) << F);
  assign hiy = $signed(20'({1'b0, bound_y}) << F);
  assign nvx = (pos_x_r[idx_r] < 0 || 20'(pos_x_r[idx_r]) > hix) ?
               neg8(vel_x_r[idx_r]) : vel_x_r[idx_r];
  assign nvy = (pos_y_r[idx_r] < 0 || 20'(pos_y_r[idx_r]) > hiy) ?
               neg8(vel_y_r[idx_r]) : vel_y_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BALLS; i++) begin
        pos_x_r[i] <= '0;
        pos_y_r[i] <= '0;
        vel_x_r[i] <= '0;
        vel_y_r[i] <= '0;
        rad_r[i]   <= '0;
      end
      idx_r     <= '0;
      sum_r     <= '0;
      sq_load_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      sq_load_r <= cmd.sq_dist;
      if (cmd.load && 32'(in_ball_index) < NUM_BALLS) begin
        pos_x_r[IdxW'(in_ball_index)] <= in_load_pos_x;
        pos_y_r[IdxW'(in_ball_index)] <= in_load_pos_y;
        vel_x_r[IdxW'(in_ball_index)] <= in_load_vel_x;
        vel_y_r[IdxW'(in_ball_index)] <= in_load_vel_y;
        rad_r[IdxW'(in_ball_index)]   <= in_load_radius;
      end
      if (cmd.first_ball) idx_r <= '0;
      if (cmd.next_ball)  idx_r <= idx_r + 1'b1;
      if (cmd.pix_start) begin
        px_r  <= in_pixel_x;
        py_r  <= in_pixel_y;
        sum_r <= '0;
      end
      if (cmd.sq_dist) begin
        sqx_r     <= dxx;
        sqy_r     <= dyy;
        cnt_r     <= '0;
      end
      if (sq_load_r) begin
        sq_src_r <= sqx_r + sqy_r;
        rem_r    <= '0;
        root_r   <= '0;
      end else if (cmd.sqrt_step) begin
        sq_src_r <= sq_src_r << 2;
        cnt_r    <= cnt_r + 1'b1;
        if (D2W'(rem_sh) >= D2W'(trial)) begin
          rem_r  <= rem_sh - D2W'(trial);
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
      end
      if (cmd.div_init) begin
        num_r  <= numer;
        drem_r <= '0;
        quo_r  <= '0;
        cnt_r  <= '0;
      end
      if (cmd.div_step) begin
        num_r <= num_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (root_r != '0 && dsh >= {1'b0, root_r}) begin
          drem_r <= dsh - {1'b0, root_r};
          quo_r  <= {quo_r[QW-2:0], 1'b1};
        end else begin
          drem_r <= dsh;
          quo_r  <= {quo_r[QW-2:0], 1'b0};
        end
      end
      if (cmd.acc) sum_r <= acc_sum[24] ? mbf_pkg::Sat24 : acc_sum[23:0];
      if (cmd.frame) begin
        vel_x_r[idx_r] <= nvx;
        vel_y_r[idx_r] <= nvy;
        pos_x_r[idx_r] <= move(pos_x_r[idx_r], nvx);
        pos_y_r[idx_r] <= move(pos_y_r[idx_r], nvy);
      end
    end
  end

endmodule
